// ----- design/a51_pkg.sv -----
// A5/1 byte cipher package: widths, tap functions, microcode types and program ROM.
// No dependencies; used by every other file of the block.
package a51_pkg;

  localparam int R1_W    = 19;
  localparam int R2_W    = 22;
  localparam int R3_W    = 23;
  localparam int FRAME_W = 22;
  localparam int KEY_W   = 64;
  localparam int BYTE_W  = 8;
  localparam int MIX_N   = 100;
  localparam int CNT_W   = 7;
  localparam int PC_W    = 3;

  // Majority clocking bits
  localparam int R1_CLK = 8;
  localparam int R2_CLK = 10;
  localparam int R3_CLK = 10;

  // Datapath operations, one per microcode step
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_LOAD_KEY,
    OP_LOAD_FRAME,
    OP_MIX,
    OP_KEYSTREAM,
    OP_EMIT
  } op_t;

  // Condition that lets a step execute
  typedef enum logic [1:0] {
    JC_ALWAYS,
    JC_START,
    JC_OUT_FREE
  } jcond_t;

  typedef struct packed {
    op_t              op;
    jcond_t           cond;
    logic [CNT_W-1:0] last;     // repeat count minus one
    logic [PC_W-1:0]  next_pc;
  } ucode_t;

  // Sequencer to datapath control
  typedef struct packed {
    op_t              op;
    logic             fire;
    logic [CNT_W-1:0] step;
  } ctrl_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_WAIT       = 3'd0;
  localparam logic [PC_W-1:0] PC_LOAD_KEY   = 3'd1;
  localparam logic [PC_W-1:0] PC_LOAD_FRAME = 3'd2;
  localparam logic [PC_W-1:0] PC_MIX        = 3'd3;
  localparam logic [PC_W-1:0] PC_KEYSTREAM  = 3'd4;
  localparam logic [PC_W-1:0] PC_EMIT       = 3'd5;

  // Program ROM
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_WAIT:       w = '{OP_WAIT,       JC_START,    CNT_W'(0),          PC_LOAD_KEY};
      PC_LOAD_KEY:   w = '{OP_LOAD_KEY,   JC_ALWAYS,   CNT_W'(KEY_W - 1),   PC_LOAD_FRAME};
      PC_LOAD_FRAME: w = '{OP_LOAD_FRAME, JC_ALWAYS,   CNT_W'(FRAME_W - 1), PC_MIX};
      PC_MIX:        w = '{OP_MIX,        JC_ALWAYS,   CNT_W'(MIX_N - 1),   PC_KEYSTREAM};
      PC_KEYSTREAM:  w = '{OP_KEYSTREAM,  JC_ALWAYS,   CNT_W'(BYTE_W - 1),  PC_EMIT};
      PC_EMIT:       w = '{OP_EMIT,       JC_OUT_FREE, CNT_W'(0),          PC_WAIT};
      default:       w = '{OP_WAIT,       JC_ALWAYS,   CNT_W'(0),          PC_WAIT};
    endcase
    return w;
  endfunction

  // Regular clocking of each register: shift left, feedback into bit 0
  function automatic logic [R1_W-1:0] clock_r1(input logic [R1_W-1:0] r);
    return {r[R1_W-2:0], r[13] ^ r[16] ^ r[17] ^ r[18]};
  endfunction

  function automatic logic [R2_W-1:0] clock_r2(input logic [R2_W-1:0] r);
    return {r[R2_W-2:0], r[20] ^ r[21]};
  endfunction

  function automatic logic [R3_W-1:0] clock_r3(input logic [R3_W-1:0] r);
    return {r[R3_W-2:0], r[7] ^ r[20] ^ r[21] ^ r[22]};
  endfunction

endpackage

// ----- design/a51_if.sv -----
// Channel interfaces of the A5/1 byte cipher: input byte, output byte, key write.
// Depends on a51_pkg for the field widths.
interface a51_in_if;
  logic                     valid;
  logic                     ready;
  logic [a51_pkg::BYTE_W-1:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface a51_out_if;
  logic                     valid;
  logic                     ready;
  logic [a51_pkg::BYTE_W-1:0] cipher_byte;
  modport source (output valid, output cipher_byte, input ready);
  modport sink (input valid, input cipher_byte, output ready);
endinterface

interface a51_cfg_if;
  logic                    valid;
  logic                    ready;
  logic [a51_pkg::KEY_W-1:0] cipher_key;
  modport source (output valid, output cipher_key, input ready);
  modport sink (input valid, input cipher_key, output ready);
endinterface

// ----- design/a51_seq.sv -----
// Microcode sequencer: program counter, repeat counter, conditional step execution.
// Depends on a51_pkg (program ROM and control types).
module a51_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             out_full,
  output logic             in_ready,
  output a51_pkg::ctrl_t   ctrl
);

  logic [a51_pkg::PC_W-1:0]  pc;
  logic [a51_pkg::CNT_W-1:0] cnt;
  a51_pkg::ucode_t           cw;
  logic                      cond_ok;
  logic                      step_last;

  assign cw = a51_pkg::ucode_rom(pc);

  // Step condition
  always_comb begin
    unique case (cw.cond)
      a51_pkg::JC_ALWAYS:   cond_ok = 1'b1;
      a51_pkg::JC_START:    cond_ok = start;
      a51_pkg::JC_OUT_FREE: cond_ok = !out_full;
      default:              cond_ok = 1'b0;
    endcase
  end

  assign step_last = (cnt == cw.last);
  assign in_ready  = (cw.op == a51_pkg::OP_WAIT);

  assign ctrl.op   = cw.op;
  assign ctrl.fire = cond_ok;
  assign ctrl.step = cnt;

  // Program counter and repeat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= a51_pkg::PC_WAIT;
      cnt <= '0;
    end else if (cond_ok) begin
      if (step_last) begin
        pc  <= cw.next_pc;
        cnt <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Repeat counter never runs past the step's count
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= cw.last)
    else $error("repeat counter beyond step count");

  // An accepted byte starts the key load at step zero
  a_start: assert property (@(posedge clk) disable iff (rst)
    (pc == a51_pkg::PC_WAIT && start) |=> (pc == a51_pkg::PC_LOAD_KEY && cnt == '0))
    else $error("accepted byte did not start key load");

  // Emitting a result returns to wait
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (pc == a51_pkg::PC_EMIT && !out_full) |=> (pc == a51_pkg::PC_WAIT))
    else $error("emit did not return to wait");

  // Program counter stays inside the program
  a_pc_range: assert property (@(posedge clk) disable iff (rst) pc <= a51_pkg::PC_EMIT)
    else $error("program counter outside program");

endmodule

// ----- design/a51_dp.sv -----
// A5/1 datapath: three LFSRs, frame counter, key register, byte register, output register.
// Depends on a51_pkg; driven by the control word of a51_seq.
module a51_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  a51_pkg::ctrl_t             ctrl,
  input  logic [a51_pkg::BYTE_W-1:0] data_byte,
  input  logic                       key_we,
  input  logic [a51_pkg::KEY_W-1:0]  key_in,
  input  logic                       out_take,
  output logic                       out_full,
  output logic [a51_pkg::BYTE_W-1:0] cipher_byte
);

  logic [a51_pkg::R1_W-1:0]    r1, r1_clk, r1_maj, r1_next;
  logic [a51_pkg::R2_W-1:0]    r2, r2_clk, r2_maj, r2_next;
  logic [a51_pkg::R3_W-1:0]    r3, r3_clk, r3_maj, r3_next;
  logic [a51_pkg::FRAME_W-1:0] frame_count;
  logic [a51_pkg::KEY_W-1:0]   cipher_key;
  logic [a51_pkg::BYTE_W-1:0]  data;
  logic                        load_bit;
  logic                        maj;
  logic                        ks_bit;

  assign r1_clk = a51_pkg::clock_r1(r1);
  assign r2_clk = a51_pkg::clock_r2(r2);
  assign r3_clk = a51_pkg::clock_r3(r3);

  // Majority clocking and keystream bit
  always_comb begin
    maj = (r1[a51_pkg::R1_CLK] & r2[a51_pkg::R2_CLK]) |
          (r1[a51_pkg::R1_CLK] & r3[a51_pkg::R3_CLK]) |
          (r2[a51_pkg::R2_CLK] & r3[a51_pkg::R3_CLK]);
    r1_maj = (r1[a51_pkg::R1_CLK] == maj) ? r1_clk : r1;
    r2_maj = (r2[a51_pkg::R2_CLK] == maj) ? r2_clk : r2;
    r3_maj = (r3[a51_pkg::R3_CLK] == maj) ? r3_clk : r3;
    ks_bit = r1_maj[a51_pkg::R1_W-1] ^ r2_maj[a51_pkg::R2_W-1] ^ r3_maj[a51_pkg::R3_W-1];
  end

  // Bit loaded this step: key bits, then frame bits
  assign load_bit = (ctrl.op == a51_pkg::OP_LOAD_KEY) ? cipher_key[ctrl.step[5:0]]
                                                       : frame_count[ctrl.step[4:0]];

  // Register update selected by the operation
  always_comb begin
    r1_next = r1;
    r2_next = r2;
    r3_next = r3;
    unique case (ctrl.op)
      a51_pkg::OP_WAIT: begin
        r1_next = '0;
        r2_next = '0;
        r3_next = '0;
      end
      a51_pkg::OP_LOAD_KEY, a51_pkg::OP_LOAD_FRAME: begin
        r1_next = {r1_clk[a51_pkg::R1_W-1:1], r1_clk[0] ^ load_bit};
        r2_next = {r2_clk[a51_pkg::R2_W-1:1], r2_clk[0] ^ load_bit};
        r3_next = {r3_clk[a51_pkg::R3_W-1:1], r3_clk[0] ^ load_bit};
      end
      a51_pkg::OP_MIX, a51_pkg::OP_KEYSTREAM: begin
        r1_next = r1_maj;
        r2_next = r2_maj;
        r3_next = r3_maj;
      end
      default: begin
      end
    endcase
  end

  // LFSRs, frame counter, key and output status
  always_ff @(posedge clk) begin
    if (rst) begin
      r1          <= '0;
      r2          <= '0;
      r3          <= '0;
      frame_count <= '0;
      cipher_key  <= '0;
      out_full    <= 1'b0;
    end else begin
      if (ctrl.fire) begin
        r1 <= r1_next;
        r2 <= r2_next;
        r3 <= r3_next;
      end
      if (key_we) begin
        cipher_key <= key_in;
      end
      if (ctrl.fire && ctrl.op == a51_pkg::OP_EMIT) begin
        frame_count <= frame_count + 1'b1;
        out_full    <= 1'b1;
      end else if (out_take) begin
        out_full <= 1'b0;
      end
    end
  end

  // Byte register: latch on request, keystream bits enter at the top
  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.op == a51_pkg::OP_WAIT) begin
      data <= data_byte;
    end else if (ctrl.fire && ctrl.op == a51_pkg::OP_KEYSTREAM) begin
      data <= {data[0] ^ ks_bit, data[a51_pkg::BYTE_W-1:1]};
    end
    if (ctrl.fire && ctrl.op == a51_pkg::OP_EMIT) begin
      cipher_byte <= data;
    end
  end

endmodule

// ----- design/a51_stream_cipher_byte.sv -----
// Top level of the A5/1 byte cipher: channel ports, sequencer and datapath.
// Depends on a51_pkg, a51_if, a51_seq and a51_dp.
//
// Each byte request is one A5/1 frame: the registers are cleared, loaded with the 64-bit key
// and the 22-bit frame number, run 100 discarded mixing steps and then 8 keystream steps whose
// bits are XORed into the byte, bit 0 first; the frame number then advances modulo 2^22.
// From acceptance until its result is in the output register, a byte passes through the
// steps accept, key load, frame load, mix, keystream and emit, and a new byte is accepted
// only after the previous one has been emitted, since the single LFSR datapath is driven by
// a microcode sequencer. The output register lets the next byte start while a result waits.
// Key writes are taken at any time but must only be made while no byte is in flight.
module a51_stream_cipher_byte (
  input  logic       clk,
  input  logic       rst,
  a51_in_if.sink     in_ch,
  a51_out_if.source  out_ch,
  a51_cfg_if.sink    cfg_ch
);

  a51_pkg::ctrl_t ctrl;
  logic           out_full;
  logic           in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_full;

  a51_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_ch.valid),
    .out_full (out_full),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  a51_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .data_byte   (in_ch.data_byte),
    .key_we      (cfg_ch.valid),
    .key_in      (cfg_ch.cipher_key),
    .out_take    (out_ch.ready),
    .out_full    (out_full),
    .cipher_byte (out_ch.cipher_byte)
  );

endmodule

// ----- verif/a51_stream_cipher_byte_checker.sv -----
// Checker for the A5/1 byte cipher: tracks key writes and byte requests, predicts each
// cipher byte and compares it with the block's output. Depends on a51_pkg and a51_if.
module a51_stream_cipher_byte_checker (
  input  logic clk,
  input  logic rst,
  a51_in_if    in_ch,
  a51_out_if   out_ch,
  a51_cfg_if   cfg_ch,
  output int   bytes_in_flight,
  output int   mismatches
);

  // Feedback tap masks of the three registers
  localparam logic [a51_pkg::R1_W-1:0] R1_TAPS = 19'h72000;   // 13, 16, 17, 18
  localparam logic [a51_pkg::R2_W-1:0] R2_TAPS = 22'h300000;  // 20, 21
  localparam logic [a51_pkg::R3_W-1:0] R3_TAPS = 23'h700080;  // 7, 20, 21, 22

  logic [a51_pkg::KEY_W-1:0]   session_key;
  logic [a51_pkg::FRAME_W-1:0] frame_num;
  logic [a51_pkg::BYTE_W-1:0]  pending_ciphers[$];
  logic [a51_pkg::BYTE_W-1:0]  want;
  int                          errs;

  // One full frame: clear, load key and frame number, mix, then XOR 8 keystream bits
  function automatic logic [a51_pkg::BYTE_W-1:0] a51_encrypt(
      input logic [a51_pkg::KEY_W-1:0]   key,
      input logic [a51_pkg::FRAME_W-1:0] frame,
      input logic [a51_pkg::BYTE_W-1:0]  din);
    logic [a51_pkg::R1_W-1:0]                   r1;
    logic [a51_pkg::R2_W-1:0]                   r2;
    logic [a51_pkg::R3_W-1:0]                   r3;
    logic [a51_pkg::KEY_W+a51_pkg::FRAME_W-1:0] seed;
    logic [a51_pkg::BYTE_W-1:0]                 dout;
    logic                                       maj;
    int                                         i;
    r1   = '0;
    r2   = '0;
    r3   = '0;
    dout = '0;
    seed = {frame, key};
    // loading: regular clocking, then the seed bit goes into bit 0
    for (i = 0; i < a51_pkg::KEY_W + a51_pkg::FRAME_W; i++) begin
      r1 = {r1[a51_pkg::R1_W-2:0], ^(r1 & R1_TAPS) ^ seed[i]};
      r2 = {r2[a51_pkg::R2_W-2:0], ^(r2 & R2_TAPS) ^ seed[i]};
      r3 = {r3[a51_pkg::R3_W-2:0], ^(r3 & R3_TAPS) ^ seed[i]};
    end
    // majority clocking; the last 8 steps give keystream bits
    for (i = 0; i < a51_pkg::MIX_N + a51_pkg::BYTE_W; i++) begin
      maj = (r1[a51_pkg::R1_CLK] & r2[a51_pkg::R2_CLK]) |
            (r1[a51_pkg::R1_CLK] & r3[a51_pkg::R3_CLK]) |
            (r2[a51_pkg::R2_CLK] & r3[a51_pkg::R3_CLK]);
      if (r1[a51_pkg::R1_CLK] == maj) r1 = {r1[a51_pkg::R1_W-2:0], ^(r1 & R1_TAPS)};
      if (r2[a51_pkg::R2_CLK] == maj) r2 = {r2[a51_pkg::R2_W-2:0], ^(r2 & R2_TAPS)};
      if (r3[a51_pkg::R3_CLK] == maj) r3 = {r3[a51_pkg::R3_W-2:0], ^(r3 & R3_TAPS)};
      if (i >= a51_pkg::MIX_N)
        dout[i-a51_pkg::MIX_N] = din[i-a51_pkg::MIX_N] ^ r1[a51_pkg::R1_W-1] ^
                                 r2[a51_pkg::R2_W-1] ^ r3[a51_pkg::R3_W-1];
    end
    return dout;
  endfunction

  // Follow the handshakes; predict on requests, compare on results
  always @(posedge clk) begin
    if (rst) begin
      session_key = '0;
      frame_num   = '0;
      pending_ciphers.delete();
      errs        = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready)
        session_key = cfg_ch.cipher_key;
      if (in_ch.valid && in_ch.ready) begin
        pending_ciphers.push_back(a51_encrypt(session_key, frame_num, in_ch.data_byte));
        frame_num = frame_num + 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_ciphers.size() == 0) begin
          $error("cipher_byte: expected none, actual %02h", out_ch.cipher_byte);
          errs++;
        end else begin
          want = pending_ciphers.pop_front();
          if (out_ch.cipher_byte !== want) begin
            $error("cipher_byte: expected %02h, actual %02h", want, out_ch.cipher_byte);
            errs++;
          end
        end
      end
    end
    bytes_in_flight <= pending_ciphers.size();
    mismatches      <= errs;
  end

endmodule

// ----- verif/a51_stream_cipher_byte_tb.sv -----
// Testbench top for the A5/1 byte cipher: clock, reset, key writes and byte stimulus,
// random back-pressure and the verdict. Depends on a51_pkg, a51_if, the block and its checker.
module a51_stream_cipher_byte_tb;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_WAIT  = 200;

  logic clk;
  logic rst;
  int   bytes_in_flight;
  int   mismatches;
  int   bytes_sent;

  a51_in_if  in_ch();
  a51_out_if out_ch();
  a51_cfg_if cfg_ch();

  a51_stream_cipher_byte DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  a51_stream_cipher_byte_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_ch          (cfg_ch),
    .bytes_in_flight (bytes_in_flight),
    .mismatches      (mismatches)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: ends the run after too long without any handshake on the input, output or key channel
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, one long hold-off, and a stretch always ready
  initial begin : receiver
    int  got;
    int  hold;
    bit  held;
    got  = 0;
    hold = 0;
    held = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) got++;
      if (got == 50 && !held) begin
        hold = HOLD_CYCLES;
        held = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (got >= 600 && got < 800) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 29);
      end
    end
  end

  // Offer one byte, with random gaps outside the steady stretch
  task automatic send_byte(input logic [a51_pkg::BYTE_W-1:0] b);
    while (!(bytes_sent >= 600 && bytes_sent < 800) && $urandom_range(99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stop offering and wait until every predicted byte has come back
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (bytes_in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_key(input logic [a51_pkg::KEY_W-1:0] k);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.cipher_key <= k;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [a51_pkg::KEY_W-1:0] k, input int n);
    int i;
    write_key(k);
    for (i = 0; i < n; i++) begin
      if (i == n / 2) wait_drain();
      send_byte((a51_pkg::BYTE_W)'($urandom_range(255)));
    end
    wait_drain();
  endtask

  // Stimulus
  initial begin
    rst               = 1'b1;
    bytes_sent        = 0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.cipher_key = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero key: byte extremes and single-bit patterns, frame number counting up
    write_key('0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h0F);
    send_byte(8'hF0);
    wait_drain();
    // all-ones key
    write_key('1);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hA5);
    wait_drain();
    // lowest and highest key bit alone
    write_key(64'h1);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_drain();
    write_key(64'h8000_0000_0000_0000);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_drain();

    // random bytes under several keys, extremes among them
    random_phase({$urandom, $urandom}, 400);
    random_phase('1, 250);
    random_phase({$urandom, $urandom}, 250);
    random_phase('0, 250);
    random_phase({$urandom, $urandom}, 250);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
